@@ rtl/rmfh_pkg.sv @@
// Shared types and codes for the recursive mutex with FIFO wait queue.
// No dependencies; imported by the controller, datapath, top level and checker.
`timescale 1ns / 1ps

package rmfh_pkg;

	// Request kind carried on s_tuser
	localparam logic CMD_LOCK   = 1'b0;
	localparam logic CMD_UNLOCK = 1'b1;

	// Fixed field widths
	localparam int TID_W   = 4;
	localparam int DEPTH_W = 8;
	localparam int DEPTH_HW_MAX = 255;
	localparam int SLOT_HW_MAX  = 16;

	// Result status carried on m_tuser
	typedef enum logic [3:0] {
		ST_ACQUIRED   = 4'd0,
		ST_NESTED     = 4'd1,
		ST_QUEUED     = 4'd2,
		ST_LOWERED    = 4'd3,
		ST_FREED      = 4'd4,
		ST_HANDOFF    = 4'd5,
		ST_NOT_OWNER  = 4'd6,
		ST_QUEUE_FULL = 4'd7,
		ST_NEST_SAT   = 4'd8
	} status_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_req;  // capture the incoming request
		logic exec;      // apply the held request and load the result register
	} ctrl_cmd_t;

endpackage

@@ rtl/recursive_mutex_fifo_handoff.sv @@
// Top level of the recursive mutex with FIFO wait queue and ownership handoff.
// Depends on rmfh_pkg, rmfh_ctrl and rmfh_dp.
`timescale 1ns / 1ps

// Each lock or unlock request is first captured into the request register, then applied:
// owner, depth and wait queue are updated and the result register is loaded.
// One request is in work at a time; the result register lets the next request be
// captured while an earlier result still waits for m_tready. The wait queue holds
// min(QUEUE_DEPTH, 16) task IDs, the nesting depth saturates at min(NEST_LIMIT, 255).
// Reset clears owner, depth and queue pointers at once; no clearing pass is needed.

module recursive_mutex_fifo_handoff
	import rmfh_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int NEST_LIMIT  = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [3:0] task_id, [7:4] zero
	input  logic [0:0]  s_tuser,   // [0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [0] woken_valid, [4:1] woken_task, [8:5] owner_task,
	                               // [16:9] lock_depth, [23:17] zero
	output logic [3:0]  m_tuser    // [3:0] status
);

	ctrl_cmd_t          cmd;
	status_t            status;
	logic               woken_valid;
	logic [TID_W-1:0]   woken_task;
	logic [TID_W-1:0]   owner_task;
	logic [DEPTH_W-1:0] lock_depth;

	rmfh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	rmfh_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.NEST_LIMIT  (NEST_LIMIT)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.in_cmd          (s_tuser[0]),
		.in_tid          (s_tdata[TID_W-1:0]),
		.out_status      (status),
		.out_woken_valid (woken_valid),
		.out_woken_task  (woken_task),
		.out_owner       (owner_task),
		.out_depth       (lock_depth)
	);

	// Result packing
	assign m_tdata = {7'd0, lock_depth, owner_task, woken_task, woken_valid};
	assign m_tuser = status;

endmodule

@@ rtl/rmfh_ctrl.sv @@
// Controller for the recursive mutex: request handshake, sequencing and result valid.
// Depends on rmfh_pkg; drives rmfh_dp through a ctrl_cmd_t command bundle.
`timescale 1ns / 1ps

module rmfh_ctrl
	import rmfh_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	output ctrl_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	// Result slot can take a new result when empty or being drained
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;

	assign cmd.load_req = s_tvalid && s_tready;
	assign cmd.exec     = (state_q == S_EXEC) && out_free;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.load_req) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (cmd.exec) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

endmodule

@@ rtl/rmfh_dp.sv @@
// Datapath for the recursive mutex: request register, owner/depth state, wait queue, result.
// Depends on rmfh_pkg; sequenced by rmfh_ctrl.
`timescale 1ns / 1ps

module rmfh_dp
	import rmfh_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int NEST_LIMIT  = 255
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ctrl_cmd_t          cmd,
	input  logic               in_cmd,
	input  logic [TID_W-1:0]   in_tid,
	output status_t            out_status,
	output logic               out_woken_valid,
	output logic [TID_W-1:0]   out_woken_task,
	output logic [TID_W-1:0]   out_owner,
	output logic [DEPTH_W-1:0] out_depth
);

	localparam int CAP       = (QUEUE_DEPTH < SLOT_HW_MAX) ? QUEUE_DEPTH : SLOT_HW_MAX;
	localparam int IDX_W     = (CAP > 1) ? $clog2(CAP) : 1;
	localparam int FILL_W    = $clog2(CAP + 1);
	localparam int DEPTH_MAX = (NEST_LIMIT < DEPTH_HW_MAX) ? NEST_LIMIT : DEPTH_HW_MAX;

	localparam logic [IDX_W-1:0]   LAST_SLOT = IDX_W'(CAP - 1);
	localparam logic [FILL_W-1:0]  FILL_CAP  = FILL_W'(CAP);
	localparam logic [DEPTH_W-1:0] DEPTH_TOP = DEPTH_W'(DEPTH_MAX);
	localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);

	// Held request
	logic             req_cmd_q;
	logic [TID_W-1:0] req_tid_q;

	// Mutex state
	logic [DEPTH_W-1:0] depth_q, depth_d;
	logic [TID_W-1:0]   owner_q, owner_d;
	logic [IDX_W-1:0]   head_q, head_d;
	logic [IDX_W-1:0]   tail_q, tail_d;
	logic [FILL_W-1:0]  fill_q, fill_d;
	logic [TID_W-1:0]   queue_q [CAP];

	logic               push;
	logic               woke;
	logic [TID_W-1:0]   woke_id;
	status_t            status_d;

	// Request decode and next state
	always_comb begin
		logic               held;
		logic               is_owner;
		logic [DEPTH_W-1:0] dec;
		held     = (depth_q != '0);
		is_owner = held && (owner_q == req_tid_q);
		dec      = depth_q - DEPTH_ONE;
		depth_d  = depth_q;
		owner_d  = owner_q;
		head_d   = head_q;
		tail_d   = tail_q;
		fill_d   = fill_q;
		push     = 1'b0;
		woke     = 1'b0;
		woke_id  = '0;
		status_d = ST_NOT_OWNER;
		if (req_cmd_q == CMD_LOCK) begin
			if (!held) begin
				depth_d  = DEPTH_ONE;
				owner_d  = req_tid_q;
				status_d = ST_ACQUIRED;
			end else if (is_owner) begin
				if (depth_q >= DEPTH_TOP) begin
					status_d = ST_NEST_SAT;
				end else begin
					depth_d  = depth_q + DEPTH_ONE;
					status_d = ST_NESTED;
				end
			end else if (fill_q >= FILL_CAP) begin
				status_d = ST_QUEUE_FULL;
			end else begin
				push     = 1'b1;
				tail_d   = (tail_q == LAST_SLOT) ? '0 : tail_q + IDX_W'(1);
				fill_d   = fill_q + FILL_W'(1);
				status_d = ST_QUEUED;
			end
		end else if (is_owner) begin
			if (dec != '0) begin
				depth_d  = dec;
				status_d = ST_LOWERED;
			end else if (fill_q == '0) begin
				depth_d  = '0;
				owner_d  = '0;
				status_d = ST_FREED;
			end else begin
				// Hand ownership to the oldest waiter
				woke     = 1'b1;
				woke_id  = queue_q[head_q];
				head_d   = (head_q == LAST_SLOT) ? '0 : head_q + IDX_W'(1);
				fill_d   = fill_q - FILL_W'(1);
				owner_d  = woke_id;
				depth_d  = DEPTH_ONE;
				status_d = ST_HANDOFF;
			end
		end
	end

	// Request capture, queue storage and result register (payload, no reset)
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_cmd_q <= in_cmd;
			req_tid_q <= in_tid;
		end
		if (cmd.exec && push) queue_q[tail_q] <= req_tid_q;
		if (cmd.exec) begin
			out_status      <= status_d;
			out_woken_valid <= woke;
			out_woken_task  <= woke_id;
			out_owner       <= (depth_d != '0) ? owner_d : '0;
			out_depth       <= depth_d;
		end
	end

	// Mutex control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			owner_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			fill_q  <= '0;
		end else if (cmd.exec) begin
			depth_q <= depth_d;
			owner_q <= owner_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			fill_q  <= fill_d;
		end
	end

endmodule

@@ rtl/rmfh_checker.sv @@
// Port-level checker for recursive_mutex_fifo_handoff, attached by bind.
// Depends on rmfh_pkg for the status codes.
`timescale 1ns / 1ps

module rmfh_checker
	import rmfh_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [3:0]  m_tuser
);

	// A stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// One request in work at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while one is in work");

	// Woken flag exactly on a handoff
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == (m_tuser == ST_HANDOFF)))
		else $error("woken flag does not match handoff status");

	// Fresh ownership starts at depth one
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_ACQUIRED || m_tuser == ST_HANDOFF) |->
		m_tdata[16:9] == 8'd1)
		else $error("new owner without depth one");

	// A free mutex reports no owner
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[16:9] == 8'd0 |-> m_tdata[8:5] == 4'd0)
		else $error("owner shown on a free mutex");

endmodule

bind recursive_mutex_fifo_handoff rmfh_checker u_rmfh_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
